// ===== hw/rtl/aootc_pkg.sv =====
// types and constants shared by the averaged on/off temperature controller
`default_nettype none

package aootc_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TEMP_W    = 13;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned HOURS_W   = 7;
  localparam int unsigned MINUTES_W = 6;
  localparam int unsigned SECONDS_W = 6;

  // divide by ten as multiply by ceil(2^19 / 10), exact for any 16-bit sum
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned PROD_W      = SUM_W + 17;

  localparam logic [SECONDS_W-1:0] LAST_SECOND = SECONDS_W'(59);
  localparam logic [MINUTES_W-1:0] LAST_MINUTE = MINUTES_W'(59);
  localparam logic [HOURS_W-1:0]   LAST_HOUR   = HOURS_W'(99);
  localparam logic [TEMP_W-1:0]    MAX_TEMP    = TEMP_W'(6553);

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_SENSOR_OFFSET      = 2'd0;
  localparam cfg_index_t REG_TARGET_TEMPERATURE = 2'd1;
  localparam cfg_index_t REG_HALTED             = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic                 pump_on;
    logic                 heater_on;
    logic                 timer_active;
    logic [TEMP_W-1:0]    average_temperature;
    logic [HOURS_W-1:0]   elapsed_hours;
    logic [MINUTES_W-1:0] elapsed_minutes;
    logic [SECONDS_W-1:0] elapsed_seconds;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aootc_if.sv =====
// valid/ready channel interfaces for samples and controller results
`default_nettype none

interface aootc_in_if;
  logic               valid;
  logic               ready;
  aootc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface aootc_out_if;
  logic                 valid;
  logic                 ready;
  aootc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/averaged_on_off_temperature_controller.sv =====
// top level: sample averaging, on/off heater control and elapsed timer
// a sample passes the input register, the accumulate stage and the result register before its result is valid
// throughput: one sample per cycle while the output is not stalled, set by the accumulate register feedback
// every sample gives exactly one result; stages fill bubbles while the output stalls
// reset (rst_n low, synchronous) clears counts, sums, timer, heater and valids;
// after reset offset and setpoint are 0 and the block is halted
`default_nettype none

module averaged_on_off_temperature_controller #(
  parameter int unsigned SAMPLES_PER_AVERAGE = 10
) (
  input  wire                          clk,
  input  wire                          rst_n,
  aootc_in_if.sink                     in_if,
  aootc_out_if.source                  out_if,
  input  wire                          cfg_we,
  input  wire aootc_pkg::cfg_index_t   cfg_index,
  input  wire [aootc_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_AVERAGE - 1);

  // configuration registers
  logic [aootc_pkg::CFG_W-1:0] offset_r;
  logic [aootc_pkg::CFG_W-1:0] target_r;
  logic                        halted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      target_r <= '0;
      halted_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aootc_pkg::REG_SENSOR_OFFSET:      offset_r <= cfg_wdata;
        aootc_pkg::REG_TARGET_TEMPERATURE: target_r <= cfg_wdata;
        aootc_pkg::REG_HALTED:             halted_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage can load when empty or when its content moves on
  logic out_valid_r;
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_free, s2_free, s1_free;

  assign out_free = !out_valid_r || out_if.ready;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_if.ready = s1_free;

  logic s1_move, s2_move;
  assign s1_move = s1_valid_r && s2_free;
  assign s2_move = s2_valid_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_r  <= in_if.valid;
      if (s2_free)  s2_valid_r  <= s1_valid_r;
      if (out_free) out_valid_r <= s2_valid_r;
    end
  end

  // stage 1: input register
  logic [aootc_pkg::SAMPLE_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (s1_free && in_if.valid) begin
      s1_sample_r <= in_if.data.raw_sample;
    end
  end

  // stage 2: accumulate, wraps modulo 2^16
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [aootc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [aootc_pkg::SUM_W-1:0] acc;
  logic                        period_done;
  logic                        s2_done_r;
  logic [aootc_pkg::SUM_W-1:0] s2_sum_r;

  always_comb begin
    acc         = aootc_pkg::SUM_W'(s1_sample_r) - offset_r + sum_r;
    period_done = (cnt_r == LAST_CNT);
    cnt_nxt     = period_done ? '0 : cnt_r + CNT_W'(1);
    sum_nxt     = period_done ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else if (s1_move) begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_done_r <= period_done;
      s2_sum_r  <= acc;
    end
  end

  // stage 3: divide by ten, heater decision, elapsed timer
  logic [aootc_pkg::TEMP_W-1:0]    held_r, held_nxt;
  logic                            heater_r, heater_nxt;
  logic [aootc_pkg::SECONDS_W-1:0] sec_r, sec_nxt;
  logic [aootc_pkg::MINUTES_W-1:0] min_r, min_nxt;
  logic [aootc_pkg::HOURS_W-1:0]   hr_r, hr_nxt;
  logic [aootc_pkg::PROD_W-1:0]    prod;
  logic [aootc_pkg::TEMP_W-1:0]    quotient;
  logic [aootc_pkg::CFG_W-1:0]     held_ext;

  always_comb begin
    prod     = aootc_pkg::PROD_W'(s2_sum_r) * aootc_pkg::PROD_W'(aootc_pkg::DIV10_MUL);
    quotient = prod[aootc_pkg::DIV10_SHIFT +: aootc_pkg::TEMP_W];
    held_nxt = s2_done_r ? quotient : held_r;
    held_ext = aootc_pkg::CFG_W'(held_nxt);
  end

  always_comb begin
    heater_nxt = heater_r;
    if (halted_r) begin
      heater_nxt = 1'b0;
    end else if (held_ext > target_r) begin
      heater_nxt = 1'b0;
    end else if (held_ext < target_r) begin
      heater_nxt = 1'b1;
    end
  end

  always_comb begin
    sec_nxt = sec_r;
    min_nxt = min_r;
    hr_nxt  = hr_r;
    if (!halted_r && s2_done_r) begin
      if (sec_r >= aootc_pkg::LAST_SECOND) begin
        sec_nxt = '0;
        if (min_r >= aootc_pkg::LAST_MINUTE) begin
          min_nxt = '0;
          hr_nxt  = (hr_r >= aootc_pkg::LAST_HOUR) ? '0 : hr_r + aootc_pkg::HOURS_W'(1);
        end else begin
          min_nxt = min_r + aootc_pkg::MINUTES_W'(1);
        end
      end else begin
        sec_nxt = sec_r + aootc_pkg::SECONDS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      heater_r <= 1'b0;
      sec_r    <= '0;
      min_r    <= '0;
      hr_r     <= '0;
    end else if (s2_move) begin
      held_r   <= held_nxt;
      heater_r <= heater_nxt;
      sec_r    <= sec_nxt;
      min_r    <= min_nxt;
      hr_r     <= hr_nxt;
    end
  end

  // result register
  aootc_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_r.pump_on             <= !halted_r;
      out_r.heater_on           <= heater_nxt;
      out_r.timer_active        <= !halted_r;
      out_r.average_temperature <= held_nxt;
      out_r.elapsed_hours       <= hr_nxt;
      out_r.elapsed_minutes     <= min_nxt;
      out_r.elapsed_seconds     <= sec_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // checks
  a_heater_needs_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.pump_on |-> !out_r.heater_on)
    else $error("heater on while pump is off");

  a_timer_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= aootc_pkg::LAST_SECOND && min_r <= aootc_pkg::LAST_MINUTE &&
    hr_r <= aootc_pkg::LAST_HOUR)
    else $error("elapsed timer out of range");

  a_timer_frozen_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(sec_r) && $stable(min_r) && $stable(hr_r))
    else $error("timer advanced while halted");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_CNT)
    else $error("sample count beyond averaging period");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= aootc_pkg::MAX_TEMP)
    else $error("averaged temperature out of range");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the averaged on/off temperature controller
`timescale 1ns / 1ps

module tb_top;

  localparam int SAMPLES_PER_AVERAGE = 10;
  localparam int DIVISOR             = 10;
  localparam int MAX_SAMPLE          = (1 << aootc_pkg::SAMPLE_W) - 1;
  localparam int RANDOM_PHASES       = 8;
  localparam int PHASE_SAMPLES       = 90;
  // ten timer seconds with the timer running
  localparam int SOAK_SAMPLES        = 100;
  localparam int DRAIN_CYCLES        = 8;
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int REPORT_LIMIT        = 10;
  localparam aootc_pkg::cfg_index_t REG_UNUSED = 2'd3;

  class thermostat_scoreboard;
    logic [aootc_pkg::CFG_W-1:0]     offset;
    logic [aootc_pkg::CFG_W-1:0]     setpoint;
    logic                            halted;
    logic [3:0]                      sample_count;
    logic [aootc_pkg::SUM_W-1:0]     sample_sum;
    logic [aootc_pkg::TEMP_W-1:0]    held_temp;
    logic                            heater;
    logic [aootc_pkg::SECONDS_W-1:0] secs;
    logic [aootc_pkg::MINUTES_W-1:0] mins;
    logic [aootc_pkg::HOURS_W-1:0]   hrs;
    aootc_pkg::out_item_t            outputs_due[$];
    int                              failures;
    int                              results_checked;
    int                              periods;
    int                              heater_on_results;
    int                              hold_band_results;

    function new();
      offset            = '0;
      setpoint          = '0;
      halted            = 1'b1;
      sample_count      = '0;
      sample_sum        = '0;
      held_temp         = '0;
      heater            = 1'b0;
      secs              = '0;
      mins              = '0;
      hrs               = '0;
      failures          = 0;
      results_checked   = 0;
      periods           = 0;
      heater_on_results = 0;
      hold_band_results = 0;
    endfunction

    function void write_register(aootc_pkg::cfg_index_t idx,
                                 logic [aootc_pkg::CFG_W-1:0] value);
      case (idx)
        aootc_pkg::REG_SENSOR_OFFSET:      offset = value;
        aootc_pkg::REG_TARGET_TEMPERATURE: setpoint = value;
        aootc_pkg::REG_HALTED:             halted = value[0];
        default: ;
      endcase
    endfunction

    // one accepted sample transaction gives exactly one controller output
    function void predict_sample(logic [aootc_pkg::SAMPLE_W-1:0] raw);
      aootc_pkg::out_item_t due;
      logic                 period_done;
      period_done = 1'b0;
      sample_sum = sample_sum + (aootc_pkg::SUM_W'(raw) - offset);
      sample_count = sample_count + 4'd1;
      if (sample_count >= 4'(SAMPLES_PER_AVERAGE)) begin
        sample_count = '0;
        held_temp = aootc_pkg::TEMP_W'(sample_sum / aootc_pkg::SUM_W'(DIVISOR));
        sample_sum = '0;
        period_done = 1'b1;
        periods++;
      end
      if (halted) begin
        heater = 1'b0;
      end else begin
        if (held_temp > setpoint) begin
          heater = 1'b0;
        end else if (held_temp < setpoint) begin
          heater = 1'b1;
        end else begin
          hold_band_results++;
        end
        if (period_done) begin
          if (secs >= aootc_pkg::LAST_SECOND) begin
            secs = '0;
            if (mins >= aootc_pkg::LAST_MINUTE) begin
              mins = '0;
              hrs = (hrs >= aootc_pkg::LAST_HOUR) ? '0 : hrs + aootc_pkg::HOURS_W'(1);
            end else begin
              mins = mins + aootc_pkg::MINUTES_W'(1);
            end
          end else begin
            secs = secs + aootc_pkg::SECONDS_W'(1);
          end
        end
      end
      if (heater) heater_on_results++;
      due.pump_on             = !halted;
      due.heater_on           = heater;
      due.timer_active        = !halted;
      due.average_temperature = held_temp;
      due.elapsed_hours       = hrs;
      due.elapsed_minutes     = mins;
      due.elapsed_seconds     = secs;
      outputs_due.push_back(due);
    endfunction

    function string describe(aootc_pkg::out_item_t item);
      return $sformatf("pump %0b heater %0b timer %0b temp %0d time %0d:%0d:%0d",
                       item.pump_on, item.heater_on, item.timer_active,
                       item.average_temperature, item.elapsed_hours,
                       item.elapsed_minutes, item.elapsed_seconds);
    endfunction

    function void check_output(aootc_pkg::out_item_t got);
      aootc_pkg::out_item_t want;
      if (outputs_due.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("error: output with no sample pending: %s", describe(got));
        return;
      end
      want = outputs_due.pop_front();
      results_checked++;
      if (want.pump_on !== got.pump_on || want.heater_on !== got.heater_on ||
          want.timer_active !== got.timer_active ||
          want.average_temperature !== got.average_temperature ||
          want.elapsed_hours !== got.elapsed_hours ||
          want.elapsed_minutes !== got.elapsed_minutes ||
          want.elapsed_seconds !== got.elapsed_seconds) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("error: output %0d mismatch", results_checked);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  aootc_pkg::cfg_index_t       cfg_index;
  logic [aootc_pkg::CFG_W-1:0] cfg_wdata;
  int                          sender_idle_pct = 0;
  int                          receiver_stall_pct = 0;
  int                          quiet_cycles = 0;
  int                          samples_sent = 0;
  thermostat_scoreboard        sb;

  aootc_in_if  in_ch();
  aootc_out_if out_ch();

  averaged_on_off_temperature_controller #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check each output transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_output(out_ch.data);
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("error: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // called right after a rising edge; leaves valid high on return
  task automatic send_sample(logic [aootc_pkg::SAMPLE_W-1:0] raw);
    aootc_pkg::in_item_t item;
    item.raw_sample = raw;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    sb.predict_sample(raw);
    samples_sent++;
  endtask

  task automatic wait_drained();
    while (sb.outputs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // call only while no sample is in flight; cfg_we stays high until end_writes
  task automatic write_reg(aootc_pkg::cfg_index_t idx, logic [aootc_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_register(idx, value);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
      default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
    endcase
  endtask

  // mostly samples that average near the setpoint so the hold band is hit
  function automatic logic [aootc_pkg::SAMPLE_W-1:0] pick_sample();
    int pick;
    int near;
    pick = $urandom_range(99);
    near = int'(sb.setpoint) + int'(sb.offset) + int'($urandom_range(6)) - 3;
    if (pick < 60) begin
      if (near < 0) near = 0;
      if (near > MAX_SAMPLE) near = MAX_SAMPLE;
      return aootc_pkg::SAMPLE_W'(near);
    end
    if (pick < 70) return $urandom_range(1) ? aootc_pkg::SAMPLE_W'(MAX_SAMPLE) : '0;
    return aootc_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic logic [aootc_pkg::CFG_W-1:0] pick_offset();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return aootc_pkg::CFG_W'($urandom);
      default: return aootc_pkg::CFG_W'($urandom_range(64));
    endcase
  endfunction

  function automatic logic [aootc_pkg::CFG_W-1:0] pick_setpoint();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return aootc_pkg::CFG_W'($urandom);
      default: return aootc_pkg::CFG_W'($urandom_range(MAX_SAMPLE));
    endcase
  endfunction

  initial begin
    sb = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = aootc_pkg::REG_SENSOR_OFFSET;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // halted after reset: averaging runs, pump, heater and timer stay off
    send_sample('0);
    send_sample(aootc_pkg::SAMPLE_W'(MAX_SAMPLE));
    for (int k = 0; k < aootc_pkg::SAMPLE_W; k++) send_sample(aootc_pkg::SAMPLE_W'(1) << k);
    in_ch.valid <= 1'b0;
    wait_drained();

    // offset above every sample wraps; unused index must not touch halt
    write_reg(aootc_pkg::REG_SENSOR_OFFSET, '1);
    write_reg(aootc_pkg::REG_TARGET_TEMPERATURE, '1);
    write_reg(aootc_pkg::REG_HALTED, '0);
    write_reg(REG_UNUSED, '1);
    end_writes();
    repeat (10) send_sample('0);
    in_ch.valid <= 1'b0;
    wait_drained();

    write_reg(aootc_pkg::REG_SENSOR_OFFSET, '0);
    write_reg(aootc_pkg::REG_TARGET_TEMPERATURE, '0);
    end_writes();
    repeat (3) send_sample(aootc_pkg::SAMPLE_W'(MAX_SAMPLE));
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_idling(phase % 4);
      write_reg(aootc_pkg::REG_SENSOR_OFFSET, pick_offset());
      write_reg(aootc_pkg::REG_TARGET_TEMPERATURE, pick_setpoint());
      write_reg(aootc_pkg::REG_HALTED, aootc_pkg::CFG_W'($urandom_range(3) == 0));
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, aootc_pkg::CFG_W'($urandom));
      end_writes();
      for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(pick_sample());
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    // free-running stretch with the timer counting
    set_idling(0);
    write_reg(aootc_pkg::REG_SENSOR_OFFSET, '0);
    write_reg(aootc_pkg::REG_TARGET_TEMPERATURE, aootc_pkg::CFG_W'($urandom_range(MAX_SAMPLE)));
    write_reg(aootc_pkg::REG_HALTED, '0);
    end_writes();
    for (int n = 0; n < SOAK_SAMPLES; n++) send_sample(pick_sample());
    in_ch.valid <= 1'b0;
    wait_drained();

    if (sb.outputs_due.size() != 0) begin
      $display("error: %0d outputs never arrived", sb.outputs_due.size());
      sb.failures += sb.outputs_due.size();
    end
    $display("ran %0d samples (%0d in the timer soak), %0d outputs checked, %0d averages",
             samples_sent, SOAK_SAMPLES, sb.results_checked, sb.periods);
    $display("heater on in %0d outputs, hold band in %0d, timer ended at %0d:%0d:%0d",
             sb.heater_on_results, sb.hold_band_results, sb.hrs, sb.mins, sb.secs);
    if (sb.failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d failures", sb.failures);
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
